// File: hdl/tty_line_discipline_core_assert.svh
// ----------------------------------------------------------------------------
// tty_line_discipline_core_assert.svh
// Assertion macros used by the line discipline RTL.
// ----------------------------------------------------------------------------
`ifndef TTY_LINE_DISCIPLINE_CORE_ASSERT_SVH
`define TTY_LINE_DISCIPLINE_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define TLD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset.
`define TLD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/tld_pkg.sv
// ----------------------------------------------------------------------------
// tld_pkg
// Types and character constants for the terminal line discipline.
// ----------------------------------------------------------------------------
package tld_pkg;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_READ,
        ST_SEND
    } tld_state_t;

    // Control characters
    localparam logic [7:0] CH_INTR = 8'h03;
    localparam logic [7:0] CH_SUSP = 8'h1A;
    localparam logic [7:0] CH_QUIT = 8'h1C;
    localparam logic [7:0] CH_FF   = 8'h0C;
    localparam logic [7:0] CH_DEL  = 8'h7F;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_BS   = 8'h08;
    localparam logic [7:0] CH_SP   = 8'h20;

    // Signal event codes
    localparam logic [1:0] SIG_NONE = 2'd0;
    localparam logic [1:0] SIG_INTR = 2'd1;
    localparam logic [1:0] SIG_SUSP = 2'd2;
    localparam logic [1:0] SIG_QUIT = 2'd3;

    // Request types
    localparam logic REQ_KBD  = 1'b0;
    localparam logic REQ_PROG = 1'b1;

    // Register indexes (byte address / 4)
    localparam int          ADDR_W    = 5;
    localparam logic [2:0]  REG_CANON = 3'd0;
    localparam logic [2:0]  REG_ECHO  = 3'd1;
    localparam logic [2:0]  REG_OPOST = 3'd2;
    localparam logic [2:0]  REG_CRLF  = 3'd3;
    localparam logic [2:0]  REG_LIMIT = 3'd4;

    localparam logic [5:0]  LIMIT_RESET = 6'd32;

endpackage

// File: hdl/tty_line_discipline_core.sv
// ----------------------------------------------------------------------------
// tty_line_discipline_core
// Terminal line discipline: signal keys, canonical line editing with erase
// echo, line release on LF or line limit, raw bypass, and LF to CR LF output mapping.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Payload
//  -------   ---------  -------------------  ----------------------------------
//  in        sink       in_valid/in_ready    req_type, data_byte
//  out       source     out_valid/out_ready  term_valid, term_byte, line_valid,
//                                            line_byte, line_end, signal_code,
//                                            last
//  apb       slave      psel/penable/pready  paddr, pwrite, pwdata, prdata
//
//  An input transaction is decoded combinationally at accept; each result then
//  passes ST_READ, which reads the line store, and ST_SEND, which loads the
//  output register. A line release holds in_ready low until its last result is
//  loaded; the sequencer and the shared index counter emit results one at a time.
//  Stalls on out_ready extend the send cycle; the output register lets the
//  next input transaction be taken while the last result still waits.
//  Reset clears the control state and the pending line count; the line store
//  holds no reset and only entries below the count are ever used.
//
`include "tty_line_discipline_core_assert.svh"

module tty_line_discipline_core
    import tld_pkg::*;
#(
    parameter int LINE_DEPTH = 32
)
(
    input  logic                clk,
    input  logic                rst_n,

    // input channel
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                req_type,
    input  logic [7:0]          data_byte,

    // output channel
    output logic                out_valid,
    input  logic                out_ready,
    output logic                term_valid,
    output logic [7:0]          term_byte,
    output logic                line_valid,
    output logic [7:0]          line_byte,
    output logic                line_end,
    output logic [1:0]          signal_code,
    output logic                last,

    // configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    // Count width holds LINE_DEPTH itself; address width indexes the store.
    localparam int CW = $clog2(LINE_DEPTH + 1);
    localparam int AW = $clog2(LINE_DEPTH);
    localparam int MW = (CW > 6) ? CW : 6;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic       canon_reg;
    logic       echo_reg;
    logic       opost_reg;
    logic       crlf_reg;
    logic [5:0] limit_reg;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            canon_reg <= 1'b1;
            echo_reg  <= 1'b1;
            opost_reg <= 1'b1;
            crlf_reg  <= 1'b1;
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:2])
                REG_CANON: canon_reg <= pwdata[0];
                REG_ECHO:  echo_reg  <= pwdata[0];
                REG_OPOST: opost_reg <= pwdata[0];
                REG_CRLF:  crlf_reg  <= pwdata[0];
                REG_LIMIT: limit_reg <= pwdata[5:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_CANON: prdata = {31'd0, canon_reg};
            REG_ECHO:  prdata = {31'd0, echo_reg};
            REG_OPOST: prdata = {31'd0, opost_reg};
            REG_CRLF:  prdata = {31'd0, crlf_reg};
            REG_LIMIT: prdata = {26'd0, limit_reg};
            default:   prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer state and per-transaction context
    // ------------------------------------------------------------------
    tld_state_t     state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;   // pending line bytes
    logic [CW-1:0]  k_reg, k_next;           // result index (shared counter)
    logic [CW-1:0]  n_reg;                   // results for this transaction
    logic [CW-1:0]  ln_reg;                  // line bytes to deliver
    logic [1:0]     tn_reg;                  // terminal bytes to send
    logic [7:0]     t0_reg, t1_reg, t2_reg;
    logic [7:0]     raw_byte_reg;
    logic           raw_reg;
    logic [1:0]     sig_reg;
    logic [7:0]     rd_data_reg;

    logic           in_accept;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_accept = in_valid && in_ready;

    // ------------------------------------------------------------------
    // Input decode: terminal bytes, release length and count update
    // ------------------------------------------------------------------
    logic [7:0]     ch;
    logic [7:0]     d_t0, d_t1, d_t2;
    logic [1:0]     d_tn;
    logic [CW-1:0]  d_ln;
    logic [CW-1:0]  d_n;
    logic [CW-1:0]  d_count;
    logic           d_raw;
    logic [1:0]     d_sig;
    logic           d_we;
    logic [CW-1:0]  cnt_st;
    logic           room;
    logic [MW-1:0]  eff_lim;

    always_comb
    begin
        d_t0    = 8'd0;
        d_t1    = 8'd0;
        d_t2    = 8'd0;
        d_tn    = 2'd0;
        d_ln    = '0;
        d_raw   = 1'b0;
        d_sig   = SIG_NONE;
        d_we    = 1'b0;
        d_count = count_reg;

        room   = (count_reg < CW'(LINE_DEPTH));
        cnt_st = room ? (count_reg + CW'(1)) : count_reg;

        // Clamp the limit to 1..LINE_DEPTH.
        eff_lim = MW'(limit_reg);
        if (eff_lim == '0)
            eff_lim = MW'(1);
        if (eff_lim > MW'(LINE_DEPTH))
            eff_lim = MW'(LINE_DEPTH);

        // Canonical translation: CR to LF, DEL to BS.
        ch = data_byte;
        if (data_byte == CH_CR)
            ch = CH_LF;
        else if (data_byte == CH_DEL)
            ch = CH_BS;

        if (req_type == REQ_PROG)
        begin
            if (opost_reg && crlf_reg && data_byte == CH_LF)
            begin
                d_t0 = CH_CR;
                d_t1 = CH_LF;
                d_tn = 2'd2;
            end
            else
            begin
                d_t0 = data_byte;
                d_tn = 2'd1;
            end
        end
        else if (data_byte == CH_INTR || data_byte == CH_SUSP ||
                 data_byte == CH_QUIT || data_byte == CH_FF)
        begin
            // Echo raw regardless of echo_reg, never deliver.
            d_t0 = data_byte;
            d_tn = 2'd1;
            priority if (data_byte == CH_INTR)
                d_sig = SIG_INTR;
            else if (data_byte == CH_SUSP)
                d_sig = SIG_SUSP;
            else if (data_byte == CH_QUIT)
                d_sig = SIG_QUIT;
            else
                d_sig = SIG_NONE;
        end
        else if (!canon_reg)
        begin
            // Raw mode: bypass the pending line.
            if (echo_reg)
            begin
                d_t0 = data_byte;
                d_tn = 2'd1;
            end
            d_raw = 1'b1;
            d_ln  = CW'(1);
        end
        else if (ch == CH_BS)
        begin
            // Erase on an empty line does nothing at all.
            if (count_reg != '0)
            begin
                d_count = count_reg - CW'(1);
                if (echo_reg)
                begin
                    d_t0 = CH_BS;
                    d_t1 = CH_SP;
                    d_t2 = CH_BS;
                    d_tn = 2'd3;
                end
            end
        end
        else if (ch == CH_LF)
        begin
            if (echo_reg)
            begin
                d_t0 = CH_CR;
                d_t1 = CH_LF;
                d_tn = 2'd2;
            end
            d_we    = room;
            d_ln    = cnt_st;
            d_count = '0;
        end
        else
        begin
            if (echo_reg)
            begin
                d_t0 = ch;
                d_tn = 2'd1;
            end
            d_we = room;
            if (MW'(cnt_st) >= eff_lim)
            begin
                d_ln    = cnt_st;
                d_count = '0;
            end
            else
            begin
                d_count = cnt_st;
            end
        end

        d_n = (CW'(d_tn) > d_ln) ? CW'(d_tn) : d_ln;
        if (d_n == '0 && d_sig != SIG_NONE)
            d_n = CW'(1);
    end

    // ------------------------------------------------------------------
    // Line store: one write port at accept, one registered read port
    // ------------------------------------------------------------------
    logic [7:0] line_mem [LINE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (in_accept && d_we)
            line_mem[count_reg[AW-1:0]] <= ch;
        if (state_reg == ST_READ)
            rd_data_reg <= line_mem[k_reg[AW-1:0]];
    end

    // Context registers hold the decoded transaction while it is emitted.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            t0_reg       <= d_t0;
            t1_reg       <= d_t1;
            t2_reg       <= d_t2;
            tn_reg       <= d_tn;
            ln_reg       <= d_ln;
            n_reg        <= d_n;
            raw_reg      <= d_raw;
            raw_byte_reg <= data_byte;
            sig_reg      <= d_sig;
        end
    end

    // ------------------------------------------------------------------
    // Result build for index k_reg
    // ------------------------------------------------------------------
    logic           out_load;
    logic           k_last;
    logic           r_term_v;
    logic [7:0]     r_term_b;
    logic           r_line_v;
    logic [7:0]     r_line_b;
    logic           r_line_e;
    logic [1:0]     r_sig;

    assign k_last   = ((k_reg + CW'(1)) == n_reg);
    assign out_load = (state_reg == ST_SEND) && (!out_valid || out_ready);

    always_comb
    begin
        r_term_v = (k_reg < CW'(tn_reg));
        r_term_b = 8'd0;
        if (r_term_v)
        begin
            unique case (k_reg[1:0])
                2'd0:    r_term_b = t0_reg;
                2'd1:    r_term_b = t1_reg;
                2'd2:    r_term_b = t2_reg;
                default: r_term_b = 8'd0;
            endcase
        end

        r_line_v = (k_reg < ln_reg);
        r_line_b = 8'd0;
        r_line_e = 1'b0;
        if (r_line_v)
        begin
            r_line_b = raw_reg ? raw_byte_reg : rd_data_reg;
            r_line_e = raw_reg || ((k_reg + CW'(1)) == ln_reg);
        end

        r_sig = (k_reg == '0) ? sig_reg : SIG_NONE;
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        count_next = count_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    count_next = d_count;
                    k_next     = '0;
                    // Transactions with no results stay idle.
                    if (d_n != '0)
                        state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                if (out_load)
                begin
                    if (k_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + CW'(1);
                        state_next = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            k_reg     <= k_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic out_valid_reg, out_valid_next;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            term_valid  <= r_term_v;
            term_byte   <= r_term_b;
            line_valid  <= r_line_v;
            line_byte   <= r_line_b;
            line_end    <= r_line_e;
            signal_code <= r_sig;
            last        <= k_last;
        end
    end

    assign out_valid = out_valid_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `TLD_ASSERT_NOW(a_count_below_depth, 1'b1, count_reg < CW'(LINE_DEPTH), "pending line overflow")
    `TLD_ASSERT_NOW(a_index_in_range, state_reg != ST_IDLE, k_reg < n_reg, "result index past count")
    `TLD_ASSERT_NEXT(a_last_returns_idle, out_load && k_last, state_reg == ST_IDLE && last, "last result did not end transaction")
    `TLD_ASSERT_NEXT(a_signal_first_only, out_load && k_reg != '0, signal_code == SIG_NONE, "signal on later result")

endmodule
